>>> hdl/lgb_pkg.sv
package lgb_pkg;

	localparam int NUM_GENERATORS = 16;
	localparam int GEN_W = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;

	localparam int SEED_W = 31;
	localparam int MULT_W = 15;
	localparam int PROD_W = SEED_W + MULT_W;
	localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
	localparam logic [31:0] LCG_MOD = 32'h7FFF_FFFF;

	localparam int DIV_STEPS = SEED_W;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RANGE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SWAP  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

	localparam int ERR_W = 3;
	localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
	localparam logic [ERR_W-1:0] ERR_GEN        = 3'd1;
	localparam logic [ERR_W-1:0] ERR_SEED       = 3'd2;
	localparam logic [ERR_W-1:0] ERR_RANGE_ZERO = 3'd3;
	localparam logic [ERR_W-1:0] ERR_RANGE_NEG  = 3'd4;

	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 40;

	typedef struct packed {
		logic accept;
		logic mul;
		logic fold;
		logic div_step;
		logic finish;
	} lgb_cmd_t;

	typedef struct packed {
		logic             error;
		logic [KIND_W-1:0] kind;
		logic             div_last;
		logic             out_busy;
	} lgb_stat_t;

endpackage

>>> hdl/lgb_ctrl.sv
module lgb_ctrl import lgb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  lgb_stat_t stat,
	output lgb_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				// Only draws need the generator step; everything else goes straight out.
				if (stat.error || stat.kind == KIND_SWAP || stat.kind == KIND_READ) begin
					state_d = ST_FIN;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d = (stat.kind == KIND_RANGE) ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/lgb_dpath.sv
module lgb_dpath import lgb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [KIND_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  lgb_cmd_t              cmd,
	output lgb_stat_t             stat
);

	logic [7:0]  in_gen;
	logic [31:0] in_seed;
	logic [31:0] in_range;
	logic        in_gen_ok;
	logic [GEN_W-1:0] in_idx;
	logic [ERR_W-1:0] in_err;

	logic [SEED_W-1:0] seed_bank_q [NUM_GENERATORS];

	logic [KIND_W-1:0] kind_q;
	logic [ERR_W-1:0]  err_q;
	logic [GEN_W-1:0]  idx_q;
	logic [SEED_W-1:0] new_seed_q;
	logic [31:0]       range_q;
	logic [SEED_W-1:0] val_q;
	logic [PROD_W-1:0] prod_q;
	logic [31:0]       rem_q;
	logic [SEED_W-1:0] dvd_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [31:0]       fold_sum;
	logic [SEED_W-1:0] folded;
	logic [31:0]       trial;
	logic [SEED_W-1:0] out_val;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign in_gen   = s_tdata[7:0];
	assign in_seed  = s_tdata[39:8];
	assign in_range = s_tdata[71:40];
	assign in_gen_ok = (9'(in_gen) < 9'(NUM_GENERATORS));
	assign in_idx = in_gen_ok ? in_gen[GEN_W-1:0] : '0;

	// A ranged draw checks the range before the generator index.
	always_comb begin
		in_err = ERR_OK;
		case (s_tuser)
			KIND_RANGE: begin
				if (in_range == 32'd0) begin
					in_err = ERR_RANGE_ZERO;
				end else if (in_range[31]) begin
					in_err = ERR_RANGE_NEG;
				end else if (!in_gen_ok) begin
					in_err = ERR_GEN;
				end
			end
			KIND_SWAP: begin
				if (!in_gen_ok) begin
					in_err = ERR_GEN;
				end else if (in_seed == 32'd0 || in_seed[31] || in_seed == LCG_MOD) begin
					in_err = ERR_SEED;
				end
			end
			default: begin
				if (!in_gen_ok) begin
					in_err = ERR_GEN;
				end
			end
		endcase
	end

	// 2^31 == 1 modulo 2^31-1, so the high part of the product folds onto the low part.
	assign fold_sum = {1'b0, prod_q[SEED_W-1:0]} + 32'(prod_q[PROD_W-1:SEED_W]);
	always_comb begin
		if (fold_sum >= LCG_MOD) begin
			folded = SEED_W'(fold_sum - LCG_MOD);
		end else begin
			folded = fold_sum[SEED_W-1:0];
		end
	end

	assign trial = {rem_q[30:0], dvd_q[SEED_W-1]};

	always_comb begin
		if (err_q != ERR_OK) begin
			out_val = '0;
		end else if (kind_q == KIND_RANGE) begin
			out_val = rem_q[SEED_W-1:0];
		end else begin
			out_val = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q     <= s_tuser;
			err_q      <= in_err;
			idx_q      <= in_idx;
			new_seed_q <= in_seed[SEED_W-1:0];
			range_q    <= in_range;
			val_q      <= seed_bank_q[in_idx];
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(val_q) * PROD_W'(LCG_MULT);
		end
		if (cmd.fold) begin
			val_q <= folded;
			dvd_q <= folded;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= (trial >= range_q) ? (trial - range_q) : trial;
			dvd_q <= {dvd_q[SEED_W-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.finish) begin
			m_tdata_q <= OUT_DATA_W'({err_q, out_val});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GENERATORS; i++) begin
				seed_bank_q[i] <= SEED_W'(1);
			end
		end else if (cmd.fold) begin
			seed_bank_q[idx_q] <= folded;
		end else if (cmd.finish && kind_q == KIND_SWAP && err_q == ERR_OK) begin
			seed_bank_q[idx_q] <= new_seed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign stat.error    = (err_q != ERR_OK);
	assign stat.kind     = kind_q;
	assign stat.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign stat.out_busy = m_tvalid_q && !m_tready;

endmodule

>>> hdl/lehmer_generator_bank_top.sv
// Channel  | Direction | Signals                             | Contents
// request  | in        | s_tvalid s_tready s_tdata s_tuser   | kind, generator, seed, range
// result   | out       | m_tvalid m_tready m_tdata           | value, error code
//
// A read, a swap or any error skips the multiply and goes from acceptance to the finish
// state; a full draw first multiplies and then folds, and a ranged draw then runs the
// restoring divider, one quotient bit per cycle, before it finishes.
// Reset returns the controller to idle and sets every seed to 1.
// A result waits in the output register while the next request is taken; a request
// finishing while that register is still held stalls until the result is taken.
module lehmer_generator_bank_top import lgb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// generator [7:0], seed_value [39:8], range_limit [71:40]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind [1:0]
	input  logic [KIND_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// value [30:0], error_code [33:31], zero [39:34]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	lgb_cmd_t  cmd;
	lgb_stat_t stat;

	lgb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lgb_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
